[rtl/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg: shared definitions of the run-length bitmap pixel decoder
// Field widths, register indexes, reset values and the types that pass
// between the front end, the block queue and the pixel back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbd_pkg;

   // Field and register widths.
   localparam int unsigned CODE_W     = 8;
   localparam int unsigned POS_W      = 11;
   localparam int unsigned COORD_W    = 16;
   localparam int unsigned COLOR_W    = 16;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Code byte layout.
   localparam int unsigned RUN_BIT       = 7;
   localparam int unsigned VALUE_BIT     = 6;
   localparam int unsigned LEN_W         = 6;
   localparam int unsigned LITERAL_COUNT = 7;
   localparam int unsigned COUNT_W       = 7;

   // Largest image dimension and queue depth defaults.
   localparam int unsigned DEFAULT_MAX_DIM = 1024;
   localparam int unsigned QUEUE_DEPTH     = 2;

   // Flip and transparency bits.
   localparam int unsigned FLIP_H_BIT   = 0;
   localparam int unsigned FLIP_V_BIT   = 1;
   localparam int unsigned TRANS_BG_BIT = 0;
   localparam int unsigned TRANS_FG_BIT = 1;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_WIDTH       = 3'd2,
      CSR_HEIGHT      = 3'd3,
      CSR_FG_COLOR    = 3'd4,
      CSR_BG_COLOR    = 3'd5,
      CSR_FLIP_MODE   = 3'd6,
      CSR_TRANS_MASK  = 3'd7
   } csr_index_type;

   // Register reset values.
   localparam logic [COORD_W-1:0] RST_ORIGIN = '0;
   localparam logic [POS_W-1:0]   RST_DIM    = 11'd1;
   localparam logic [COLOR_W-1:0] RST_FG     = 16'hFFFF;
   localparam logic [COLOR_W-1:0] RST_BG     = 16'h0000;
   localparam logic [MODE_W-1:0]  RST_MODE   = '0;

   // Configuration as seen by the decoder, with the sizes already limited.
   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [POS_W-1:0]   width;
      logic [POS_W-1:0]   height;
      logic [COLOR_W-1:0] fg_color;
      logic [COLOR_W-1:0] bg_color;
      logic [MODE_W-1:0]  flip_mode;
      logic [MODE_W-1:0]  trans_mask;
   } cfg_type;

   // One classified code byte waiting for the pixel back end.
   typedef struct packed {
      logic                     is_run;
      logic                     run_value;
      logic [LITERAL_COUNT-1:0] lits;
      logic [LITERAL_COUNT-1:0] vis_mask;
      logic [COUNT_W-1:0]       draw_count;
      logic [POS_W-1:0]         column;
      logic [COORD_W-1:0]       pixel_y;
   } block_type;

endpackage

[rtl/rbd_if.sv]
// ----------------------------------------------------------------------------
// rbd_if: channel interfaces of the run-length bitmap pixel decoder
// A request channel that carries code bytes and a response channel that
// carries drawn pixels, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rbd_req_if;
   logic                       valid;
   logic                       ready;
   logic [rbd_pkg::CODE_W-1:0] code_byte;
   logic                       start_image;

   modport source (output valid, output code_byte, output start_image, input ready);
   modport sink   (input valid, input code_byte, input start_image, output ready);
endinterface

interface rbd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rbd_pkg::COORD_W-1:0] pixel_x;
   logic signed [rbd_pkg::COORD_W-1:0] pixel_y;
   logic        [rbd_pkg::COLOR_W-1:0] pixel_color;
   logic                               last_of_block;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                   output last_of_block, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                   input last_of_block, output ready);
endinterface

[rtl/rbd_front.sv]
// ----------------------------------------------------------------------------
// rbd_front: code byte front end
// Accepts code bytes, keeps the column and row position, works out which
// pixels of the byte fall inside the row and are visible, and queues the
// block for the back end. Blocks with nothing to draw are dropped here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbd_front (
   input  logic               clock,
   input  logic               reset,
   rbd_req_if.sink            req,
   input  rbd_pkg::cfg_type   cfg,
   input  logic               queue_full,
   output logic               push,
   output rbd_pkg::block_type push_data
);

   localparam int unsigned POS_W   = rbd_pkg::POS_W;
   localparam int unsigned COORD_W = rbd_pkg::COORD_W;
   localparam int unsigned COUNT_W = rbd_pkg::COUNT_W;
   localparam int unsigned LIT_N   = rbd_pkg::LITERAL_COUNT;

   logic [POS_W-1:0]   column_ff, column_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic               accept;
   logic [POS_W-1:0]   col_s;
   logic [POS_W-1:0]   row_s;
   logic               is_run;
   logic               run_value;
   logic [COUNT_W-1:0] count;
   logic [POS_W:0]     avail;
   logic [COUNT_W-1:0] draw_count;
   logic [COORD_W-1:0] row_off;
   logic [LIT_N-1:0]   lits;
   logic [LIT_N-1:0]   vis_mask;
   logic               run_trans;
   logic               drop;
   logic [POS_W:0]     col_sum;
   logic [POS_W-1:0]   row_inc;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   // Start of image resets the position before the byte is decoded.
   assign col_s = req.start_image ? '0 : column_ff;
   assign row_s = req.start_image ? '0 : row_ff;

   // Classify the byte and count its pixels.
   assign is_run    = req.code_byte[rbd_pkg::RUN_BIT];
   assign run_value = req.code_byte[rbd_pkg::VALUE_BIT];
   assign count     = is_run
                      ? (COUNT_W'(req.code_byte[rbd_pkg::LEN_W-1:0]) + COUNT_W'(1))
                      : COUNT_W'(LIT_N);

   // Pixels left before the row end; the rest of the byte is padding.
   assign avail      = (col_s < cfg.width) ? ({1'b0, cfg.width} - {1'b0, col_s}) : '0;
   assign draw_count = ((POS_W+1)'(count) < avail) ? count : avail[COUNT_W-1:0];

   // Screen row, mirrored inside the image when vertical flip is on.
   assign row_off = cfg.flip_mode[rbd_pkg::FLIP_V_BIT]
                    ? (COORD_W'(cfg.height) - COORD_W'(1) - COORD_W'(row_s))
                    : COORD_W'(row_s);

   // Literal pixel order and visibility, first pixel in bit 0.
   always_comb begin
      for (int i = 0; i < LIT_N; i++) begin
         lits[i]     = req.code_byte[LIT_N-1-i];
         vis_mask[i] = (COUNT_W'(i) < draw_count) &&
                       !(lits[i] ? cfg.trans_mask[rbd_pkg::TRANS_FG_BIT]
                                 : cfg.trans_mask[rbd_pkg::TRANS_BG_BIT]);
      end
   end

   assign run_trans = run_value ? cfg.trans_mask[rbd_pkg::TRANS_FG_BIT]
                                : cfg.trans_mask[rbd_pkg::TRANS_BG_BIT];
   assign drop      = is_run ? ((draw_count == '0) || run_trans) : (vis_mask == '0);

   assign push                 = accept && !drop;
   assign push_data.is_run     = is_run;
   assign push_data.run_value  = run_value;
   assign push_data.lits       = lits;
   assign push_data.vis_mask   = vis_mask;
   assign push_data.draw_count = draw_count;
   assign push_data.column     = col_s;
   assign push_data.pixel_y    = cfg.origin_y + row_off;

   // Position advance: a full row wraps the column and moves to the next row.
   assign col_sum = {1'b0, col_s} + (POS_W+1)'(count);
   assign row_inc = row_s + POS_W'(1);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (col_sum >= {1'b0, cfg.width}) begin
            column_in = '0;
            row_in    = (row_inc >= cfg.height) ? '0 : row_inc;
         end else begin
            column_in = col_sum[POS_W-1:0];
            row_in    = row_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

[rtl/rbd_queue.sv]
// ----------------------------------------------------------------------------
// rbd_queue: block queue between front end and back end
// A short first-in first-out buffer of classified blocks so that the front
// end keeps taking bytes while the back end draws.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbd_queue #(
   parameter int unsigned DEPTH = rbd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rbd_pkg::block_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output rbd_pkg::block_type pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rbd_pkg::block_type slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/rbd_back.sv]
// ----------------------------------------------------------------------------
// rbd_back: pixel back end
// Steps through one queued block a pixel slot per cycle unless a visible slot waits on
// the response, skips hidden literal pixels, and places each drawn pixel in the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbd_back (
   input  logic               clock,
   input  logic               reset,
   input  rbd_pkg::cfg_type   cfg,
   input  logic               queue_valid,
   input  rbd_pkg::block_type queue_data,
   output logic               pop,
   rbd_rsp_if.source          rsp
);

   localparam int unsigned POS_W   = rbd_pkg::POS_W;
   localparam int unsigned COORD_W = rbd_pkg::COORD_W;
   localparam int unsigned COLOR_W = rbd_pkg::COLOR_W;
   localparam int unsigned COUNT_W = rbd_pkg::COUNT_W;
   localparam int unsigned LIT_N   = rbd_pkg::LITERAL_COUNT;

   logic               active_ff, active_in;
   logic               is_run_ff;
   logic               run_value_ff;
   logic [LIT_N-1:0]   lits_ff;
   logic [LIT_N-1:0]   mask_ff;
   logic [COUNT_W-1:0] remain_ff;
   logic [POS_W-1:0]   column_ff;
   logic [COORD_W-1:0] pixel_y_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff;
   logic [COORD_W-1:0] rsp_y_ff;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic               rsp_last_ff;

   logic               cur_vis;
   logic               cur_set;
   logic               cur_last;
   logic               out_free;
   logic               step;
   logic               emit;
   logic               done;
   logic               load;
   logic [COORD_W-1:0] col_off;

   // Current pixel slot.
   assign cur_vis  = is_run_ff || mask_ff[0];
   assign cur_set  = is_run_ff ? run_value_ff : lits_ff[0];
   assign cur_last = is_run_ff ? (remain_ff == COUNT_W'(1)) : (mask_ff[LIT_N-1:1] == '0);

   // Hidden slots pass without waiting for the response side.
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign step     = active_ff && (!cur_vis || out_free);
   assign emit     = step && cur_vis;
   assign done     = emit && cur_last;
   assign load     = !active_ff || done;
   assign pop      = load && queue_valid;

   // Screen column, mirrored inside the image when horizontal flip is on.
   assign col_off = cfg.flip_mode[rbd_pkg::FLIP_H_BIT]
                    ? (COORD_W'(cfg.width) - COORD_W'(1) - COORD_W'(column_ff))
                    : COORD_W'(column_ff);

   assign active_in = load ? queue_valid : active_ff;

   // Block walk: load a queued block or move to the next slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         is_run_ff    <= queue_data.is_run;
         run_value_ff <= queue_data.run_value;
         lits_ff      <= queue_data.lits;
         mask_ff      <= queue_data.vis_mask;
         remain_ff    <= queue_data.draw_count;
         column_ff    <= queue_data.column;
         pixel_y_ff   <= queue_data.pixel_y;
      end else if (step) begin
         lits_ff   <= lits_ff >> 1;
         mask_ff   <= mask_ff >> 1;
         remain_ff <= remain_ff - COUNT_W'(1);
         column_ff <= column_ff + POS_W'(1);
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff     <= cfg.origin_x + col_off;
         rsp_y_ff     <= pixel_y_ff;
         rsp_color_ff <= cur_set ? cfg.fg_color : cfg.bg_color;
         rsp_last_ff  <= cur_last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pixel_x       = rsp_x_ff;
   assign rsp.pixel_y       = rsp_y_ff;
   assign rsp.pixel_color   = rsp_color_ff;
   assign rsp.last_of_block = rsp_last_ff;

endmodule

[rtl/rle_bitmap_pixel_decoder_unit.sv]
// With the back end idle, a byte's visible first pixel passes through the queue slot, the
// back end's block registers and the response register before it is on the response.
// The back end steps one pixel slot per cycle unless a visible slot waits on the response;
// a literal byte ends at its last visible pixel, a run at its last pixel inside the row.
// A two-entry block queue lets bytes be taken while the back end draws; hidden bytes are never queued.
// Synchronous reset clears the position, the queue and the response valid, and resets the configuration registers.
// ----------------------------------------------------------------------------
// rle_bitmap_pixel_decoder_unit: run-length monochrome bitmap decoder
// Holds the configuration registers and joins the front end, the block
// queue and the pixel back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_bitmap_pixel_decoder_unit #(
   parameter int unsigned MAX_DIM = rbd_pkg::DEFAULT_MAX_DIM
) (
   input  logic                             clock,
   input  logic                             reset,
   rbd_req_if.sink                          req_ch,
   rbd_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [rbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned POS_W   = rbd_pkg::POS_W;
   localparam int unsigned COORD_W = rbd_pkg::COORD_W;
   localparam int unsigned COLOR_W = rbd_pkg::COLOR_W;
   localparam int unsigned MODE_W  = rbd_pkg::MODE_W;
   localparam int unsigned POS_MAX = (1 << POS_W) - 1;
   localparam int unsigned DIM_LIM = (MAX_DIM > POS_MAX) ? POS_MAX : MAX_DIM;

   logic [COORD_W-1:0] origin_x_ff;
   logic [COORD_W-1:0] origin_y_ff;
   logic [POS_W-1:0]   width_ff;
   logic [POS_W-1:0]   height_ff;
   logic [COLOR_W-1:0] fg_color_ff;
   logic [COLOR_W-1:0] bg_color_ff;
   logic [MODE_W-1:0]  flip_mode_ff;
   logic [MODE_W-1:0]  trans_mask_ff;

   rbd_pkg::cfg_type   cfg;
   rbd_pkg::block_type push_data;
   rbd_pkg::block_type pop_data;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= rbd_pkg::RST_ORIGIN;
         origin_y_ff   <= rbd_pkg::RST_ORIGIN;
         width_ff      <= rbd_pkg::RST_DIM;
         height_ff     <= rbd_pkg::RST_DIM;
         fg_color_ff   <= rbd_pkg::RST_FG;
         bg_color_ff   <= rbd_pkg::RST_BG;
         flip_mode_ff  <= rbd_pkg::RST_MODE;
         trans_mask_ff <= rbd_pkg::RST_MODE;
      end else if (csr_we) begin
         unique case (rbd_pkg::csr_index_type'(csr_index))
            rbd_pkg::CSR_ORIGIN_X:   origin_x_ff   <= csr_wdata[COORD_W-1:0];
            rbd_pkg::CSR_ORIGIN_Y:   origin_y_ff   <= csr_wdata[COORD_W-1:0];
            rbd_pkg::CSR_WIDTH:      width_ff      <= csr_wdata[POS_W-1:0];
            rbd_pkg::CSR_HEIGHT:     height_ff     <= csr_wdata[POS_W-1:0];
            rbd_pkg::CSR_FG_COLOR:   fg_color_ff   <= csr_wdata[COLOR_W-1:0];
            rbd_pkg::CSR_BG_COLOR:   bg_color_ff   <= csr_wdata[COLOR_W-1:0];
            rbd_pkg::CSR_FLIP_MODE:  flip_mode_ff  <= csr_wdata[MODE_W-1:0];
            rbd_pkg::CSR_TRANS_MASK: trans_mask_ff <= csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sizes limited to the largest supported dimension.
   assign cfg.origin_x   = origin_x_ff;
   assign cfg.origin_y   = origin_y_ff;
   assign cfg.width      = (width_ff > POS_W'(DIM_LIM)) ? POS_W'(DIM_LIM) : width_ff;
   assign cfg.height     = (height_ff > POS_W'(DIM_LIM)) ? POS_W'(DIM_LIM) : height_ff;
   assign cfg.fg_color   = fg_color_ff;
   assign cfg.bg_color   = bg_color_ff;
   assign cfg.flip_mode  = flip_mode_ff;
   assign cfg.trans_mask = trans_mask_ff;

   rbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   rbd_queue #(
      .DEPTH (rbd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_valid),
      .pop_data  (pop_data)
   );

   rbd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_valid (queue_valid),
      .queue_data  (pop_data),
      .pop         (pop),
      .rsp         (rsp_ch)
   );

endmodule
